### hdl/ecalu_pkg.sv
// Shared operation codes and field widths of the 8-bit CPU ALU.
`timescale 1ns / 1ps

package ecalu_pkg;

    localparam int unsigned CMD_W   = 5;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned IN_W    = 48;
    localparam int unsigned OUT_W   = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 5'd0,
        CMD_ADC   = 5'd1,
        CMD_SUB   = 5'd2,
        CMD_SBC   = 5'd3,
        CMD_AND   = 5'd4,
        CMD_OR    = 5'd5,
        CMD_XOR   = 5'd6,
        CMD_CP    = 5'd7,
        CMD_INC8  = 5'd8,
        CMD_DEC8  = 5'd9,
        CMD_ADDHL = 5'd10,
        CMD_INC16 = 5'd11,
        CMD_DEC16 = 5'd12,
        CMD_DAA   = 5'd13,
        CMD_CPL   = 5'd14,
        CMD_CCF   = 5'd15,
        CMD_SCF   = 5'd16
    } cmd_t;

    typedef struct packed {
        logic carry;
        logic half;
        logic sub;
        logic zero;
    } flags_t;

endpackage

### hdl/eight_bit_cpu_alu_with_flags.sv
// Top level: registered accumulator ALU of an 8-bit CPU with Z, N, H and C flags.
//
// Usage:
//   Input stream s_axis: one transfer per instruction. s_axis_tuser carries the
//   operation code, s_axis_tdata the accumulator, HL pair, operand and flags.
//   Output stream m_axis: one transfer per input transfer, in order, with the
//   new accumulator, the word result and the new flags.
//   Path: an input transfer goes into the input register, then through one pass
//   of ALU logic into the result register that drives m_axis.
//   Throughput: one item per cycle while m_axis_tready is high; one pass
//   through the 8-bit and 16-bit adders between the registers sets that figure.
//   Reset: rst_n clears both valid bits; no result is shown until an item
//   arrives. Payload registers are not reset.
//   Stall: while m_axis_tready is low the result holds; an empty input register
//   still takes one more item, after which s_axis_tready drops until the
//   receiver takes the held result.
`timescale 1ns / 1ps

module eight_bit_cpu_alu_with_flags (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [7:0] acc_in, [23:8] pair_in, [39:24] operand, [40] zero_in,
    // [41] sub_in, [42] half_in, [43] carry_in, [47:44] zero
    input  logic [ecalu_pkg::IN_W-1:0]    s_axis_tdata,
    // [4:0] cmd
    input  logic [ecalu_pkg::CMD_W-1:0]   s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] acc_out, [23:8] word_out, [24] zero_out, [25] sub_out,
    // [26] half_out, [27] carry_out, [31:28] zero
    output logic [ecalu_pkg::OUT_W-1:0]   m_axis_tdata
);

    logic                                 s1_valid_reg;
    logic [ecalu_pkg::CMD_W-1:0]          s1_cmd_reg;
    logic [ecalu_pkg::BYTE_W-1:0]         s1_acc_reg;
    logic [ecalu_pkg::WORD_W-1:0]         s1_pair_reg;
    logic [ecalu_pkg::WORD_W-1:0]         s1_opnd_reg;
    ecalu_pkg::flags_t                    s1_flags_reg;

    logic                                 out_valid_reg;
    logic [ecalu_pkg::BYTE_W-1:0]         out_acc_reg;
    logic [ecalu_pkg::WORD_W-1:0]         out_word_reg;
    ecalu_pkg::flags_t                    out_flags_reg;

    logic [ecalu_pkg::BYTE_W-1:0]         out_acc_next;
    logic [ecalu_pkg::WORD_W-1:0]         out_word_next;
    ecalu_pkg::flags_t                    out_flags_next;

    logic                                 s1_ready;
    logic                                 out_ready;
    logic                                 in_xfer;

    logic [ecalu_pkg::BYTE_W-1:0]         op8;
    logic                                 arith_sub;
    logic                                 arith_cin;
    logic [ecalu_pkg::BYTE_W:0]           arith_r;
    logic                                 arith_h;
    logic [ecalu_pkg::WORD_W:0]           hl_sum;
    logic [ecalu_pkg::BYTE_W-1:0]         inc8_r;
    logic [ecalu_pkg::BYTE_W-1:0]         dec8_r;
    logic [ecalu_pkg::BYTE_W-1:0]         daa_adj;
    logic                                 daa_c;
    logic [ecalu_pkg::BYTE_W-1:0]         daa_r;
    logic [ecalu_pkg::BYTE_W-1:0]         logic_r;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s1_ready      = !s1_valid_reg || out_ready;
    assign s_axis_tready = s1_ready;
    assign in_xfer       = s_axis_tvalid && s1_ready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_flags_reg.carry, out_flags_reg.half,
                            out_flags_reg.sub, out_flags_reg.zero,
                            out_word_reg, out_acc_reg};

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_cmd_reg         <= s_axis_tuser;
            s1_acc_reg         <= s_axis_tdata[7:0];
            s1_pair_reg        <= s_axis_tdata[23:8];
            s1_opnd_reg        <= s_axis_tdata[39:24];
            s1_flags_reg.zero  <= s_axis_tdata[40];
            s1_flags_reg.sub   <= s_axis_tdata[41];
            s1_flags_reg.half  <= s_axis_tdata[42];
            s1_flags_reg.carry <= s_axis_tdata[43];
        end
    end

    // Shared datapath
    assign op8       = s1_opnd_reg[7:0];
    assign arith_sub = (s1_cmd_reg == ecalu_pkg::CMD_SUB) || (s1_cmd_reg == ecalu_pkg::CMD_SBC)
                       || (s1_cmd_reg == ecalu_pkg::CMD_CP);
    assign arith_cin = ((s1_cmd_reg == ecalu_pkg::CMD_ADC) || (s1_cmd_reg == ecalu_pkg::CMD_SBC))
                       && s1_flags_reg.carry;
    assign arith_r   = arith_sub
                       ? ({1'b0, s1_acc_reg} - {1'b0, op8} - {8'd0, arith_cin})
                       : ({1'b0, s1_acc_reg} + {1'b0, op8} + {8'd0, arith_cin});
    assign arith_h   = s1_acc_reg[4] ^ op8[4] ^ arith_r[4];
    assign hl_sum    = {1'b0, s1_pair_reg} + {1'b0, s1_opnd_reg};
    assign inc8_r    = op8 + 8'd1;
    assign dec8_r    = op8 - 8'd1;

    always_comb
    begin
        daa_adj = 8'd0;
        daa_c   = s1_flags_reg.carry;
        if (s1_flags_reg.sub)
        begin
            if (s1_flags_reg.half)
                daa_adj[3:0] = 4'h6;
            if (s1_flags_reg.carry)
                daa_adj[7:4] = 4'h6;
            daa_r = s1_acc_reg - daa_adj;
        end
        else
        begin
            if (s1_flags_reg.half || (s1_acc_reg[3:0] > 4'h9))
                daa_adj[3:0] = 4'h6;
            if (s1_flags_reg.carry || (s1_acc_reg > 8'h99))
            begin
                daa_adj[7:4] = 4'h6;
                daa_c        = 1'b1;
            end
            daa_r = s1_acc_reg + daa_adj;
        end
    end

    always_comb
    begin
        out_acc_next   = s1_acc_reg;
        out_word_next  = '0;
        out_flags_next = s1_flags_reg;
        logic_r        = s1_acc_reg & op8;
        unique case (s1_cmd_reg)
            ecalu_pkg::CMD_ADD, ecalu_pkg::CMD_ADC,
            ecalu_pkg::CMD_SUB, ecalu_pkg::CMD_SBC:
            begin
                out_acc_next         = arith_r[7:0];
                out_flags_next.zero  = (arith_r[7:0] == 8'd0);
                out_flags_next.sub   = arith_sub;
                out_flags_next.half  = arith_h;
                out_flags_next.carry = arith_r[8];
            end
            ecalu_pkg::CMD_CP:
            begin
                out_flags_next.zero  = (arith_r[7:0] == 8'd0);
                out_flags_next.sub   = 1'b1;
                out_flags_next.half  = arith_h;
                out_flags_next.carry = arith_r[8];
            end
            ecalu_pkg::CMD_AND, ecalu_pkg::CMD_OR, ecalu_pkg::CMD_XOR:
            begin
                if (s1_cmd_reg == ecalu_pkg::CMD_OR)
                    logic_r = s1_acc_reg | op8;
                else if (s1_cmd_reg == ecalu_pkg::CMD_XOR)
                    logic_r = s1_acc_reg ^ op8;
                out_acc_next         = logic_r;
                out_flags_next.zero  = (logic_r == 8'd0);
                out_flags_next.sub   = 1'b0;
                out_flags_next.half  = (s1_cmd_reg == ecalu_pkg::CMD_AND);
                out_flags_next.carry = 1'b0;
            end
            ecalu_pkg::CMD_INC8:
            begin
                out_word_next       = {8'd0, inc8_r};
                out_flags_next.zero = (inc8_r == 8'd0);
                out_flags_next.sub  = 1'b0;
                out_flags_next.half = (op8[3:0] == 4'hF);
            end
            ecalu_pkg::CMD_DEC8:
            begin
                out_word_next       = {8'd0, dec8_r};
                out_flags_next.zero = (dec8_r == 8'd0);
                out_flags_next.sub  = 1'b1;
                out_flags_next.half = (op8[3:0] == 4'h0);
            end
            ecalu_pkg::CMD_ADDHL:
            begin
                out_word_next        = hl_sum[15:0];
                out_flags_next.sub   = 1'b0;
                out_flags_next.half  = s1_pair_reg[12] ^ s1_opnd_reg[12] ^ hl_sum[12];
                out_flags_next.carry = hl_sum[16];
            end
            ecalu_pkg::CMD_INC16:
            begin
                out_word_next = s1_opnd_reg + 16'd1;
            end
            ecalu_pkg::CMD_DEC16:
            begin
                out_word_next = s1_opnd_reg - 16'd1;
            end
            ecalu_pkg::CMD_DAA:
            begin
                out_acc_next         = daa_r;
                out_flags_next.zero  = (daa_r == 8'd0);
                out_flags_next.half  = 1'b0;
                out_flags_next.carry = daa_c;
            end
            ecalu_pkg::CMD_CPL:
            begin
                out_acc_next        = ~s1_acc_reg;
                out_flags_next.sub  = 1'b1;
                out_flags_next.half = 1'b1;
            end
            ecalu_pkg::CMD_CCF:
            begin
                out_flags_next.carry = ~s1_flags_reg.carry;
                out_flags_next.sub   = 1'b0;
                out_flags_next.half  = 1'b0;
            end
            ecalu_pkg::CMD_SCF:
            begin
                out_flags_next.carry = 1'b1;
                out_flags_next.sub   = 1'b0;
                out_flags_next.half  = 1'b0;
            end
            default:
            begin
                out_acc_next = s1_acc_reg;
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
        begin
            out_acc_reg   <= out_acc_next;
            out_word_reg  <= out_word_next;
            out_flags_reg <= out_flags_next;
        end
    end

endmodule

### hdl/ecalu_checker.sv
// Port-level checker for the 8-bit CPU ALU and its bind to the top level.
`timescale 1ns / 1ps

module ecalu_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [ecalu_pkg::OUT_W-1:0]   m_axis_tdata
);

    logic in_xfer;

    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // Accept input whenever the output side is empty
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // An accepted transfer reaches the output via the input and result registers if the receiver is ready
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing after two cycles");

    // Nothing appears at the output without a preceding input transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_xfer, 2))
        else $error("result without input transfer");

endmodule

bind eight_bit_cpu_alu_with_flags ecalu_checker u_ecalu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/tb_eight_bit_cpu_alu_with_flags.sv
// Stream testbench for the 8-bit CPU ALU: directed table, random items, flag-accurate predictor.
`timescale 1ns / 1ps

module tb_eight_bit_cpu_alu_with_flags;

    localparam int unsigned N_DIRECTED   = 25;
    localparam int unsigned RANDOM_ITEMS = 1900;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_AT      = 600;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned STEADY_FROM  = 1200;
    localparam int unsigned STEADY_TO    = 1400;
    localparam int unsigned MAX_REPORTS  = 200;

    localparam logic [ecalu_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 5'd17;
    localparam logic [ecalu_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 5'd31;

    typedef struct packed {
        logic [ecalu_pkg::BYTE_W-1:0] acc;
        logic [ecalu_pkg::WORD_W-1:0] word;
        ecalu_pkg::flags_t            flags;
    } alu_result_t;

    typedef struct packed {
        logic [ecalu_pkg::CMD_W-1:0]  cmd;
        logic [ecalu_pkg::BYTE_W-1:0] acc;
        logic [ecalu_pkg::WORD_W-1:0] pair;
        logic [ecalu_pkg::WORD_W-1:0] opnd;
        ecalu_pkg::flags_t            flags;
        logic                         typed;
        alu_result_t                  want;
    } stim_row_t;

    // flags columns read carry, half, sub, zero from the left
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{ecalu_pkg::CMD_ADD,   8'hFF, 16'h0000, 16'h0001, 4'b0000, 1'b1,
          '{8'h00, 16'h0000, 4'b1101}},
        '{ecalu_pkg::CMD_ADC,   8'hFF, 16'h0000, 16'h0000, 4'b1000, 1'b0, '0},
        '{ecalu_pkg::CMD_SUB,   8'h00, 16'h0000, 16'h0001, 4'b0000, 1'b1,
          '{8'hFF, 16'h0000, 4'b1110}},
        '{ecalu_pkg::CMD_SBC,   8'h10, 16'h0000, 16'h000F, 4'b1000, 1'b0, '0},
        '{ecalu_pkg::CMD_AND,   8'h00, 16'h0000, 16'hFFFF, 4'b0000, 1'b1,
          '{8'h00, 16'h0000, 4'b0101}},
        '{ecalu_pkg::CMD_OR,    8'h00, 16'hFFFF, 16'h0000, 4'b1111, 1'b1,
          '{8'h00, 16'h0000, 4'b0001}},
        '{ecalu_pkg::CMD_XOR,   8'hFF, 16'h0000, 16'h00FF, 4'b0000, 1'b1,
          '{8'h00, 16'h0000, 4'b0001}},
        '{ecalu_pkg::CMD_CP,    8'h42, 16'h0000, 16'h1242, 4'b0000, 1'b1,
          '{8'h42, 16'h0000, 4'b0011}},
        '{ecalu_pkg::CMD_CP,    8'h00, 16'h0000, 16'h0001, 4'b0000, 1'b0, '0},
        '{ecalu_pkg::CMD_INC8,  8'h37, 16'h0000, 16'hAAFF, 4'b1000, 1'b1,
          '{8'h37, 16'h0000, 4'b1101}},
        '{ecalu_pkg::CMD_DEC8,  8'h37, 16'h0000, 16'hFF00, 4'b0000, 1'b1,
          '{8'h37, 16'h00FF, 4'b0110}},
        '{ecalu_pkg::CMD_ADDHL, 8'h37, 16'hFFFF, 16'h0001, 4'b0001, 1'b1,
          '{8'h37, 16'h0000, 4'b1101}},
        '{ecalu_pkg::CMD_ADDHL, 8'h37, 16'h0FFF, 16'h0001, 4'b0000, 1'b0, '0},
        '{ecalu_pkg::CMD_INC16, 8'h37, 16'h0000, 16'hFFFF, 4'b1111, 1'b1,
          '{8'h37, 16'h0000, 4'b1111}},
        '{ecalu_pkg::CMD_DEC16, 8'h37, 16'h0000, 16'h0000, 4'b0000, 1'b1,
          '{8'h37, 16'hFFFF, 4'b0000}},
        '{ecalu_pkg::CMD_DAA,   8'h9A, 16'h0000, 16'h0000, 4'b0000, 1'b0, '0},
        '{ecalu_pkg::CMD_DAA,   8'h15, 16'h0000, 16'h0000, 4'b0100, 1'b0, '0},
        '{ecalu_pkg::CMD_DAA,   8'h00, 16'h0000, 16'h0000, 4'b1110, 1'b0, '0},
        '{ecalu_pkg::CMD_DAA,   8'h00, 16'h0000, 16'h0000, 4'b0000, 1'b1,
          '{8'h00, 16'h0000, 4'b0001}},
        '{ecalu_pkg::CMD_CPL,   8'h00, 16'h0000, 16'h0000, 4'b0000, 1'b1,
          '{8'hFF, 16'h0000, 4'b0110}},
        '{ecalu_pkg::CMD_CCF,   8'h5A, 16'h0000, 16'h0000, 4'b1111, 1'b1,
          '{8'h5A, 16'h0000, 4'b0001}},
        '{ecalu_pkg::CMD_SCF,   8'h5A, 16'h0000, 16'h0000, 4'b0000, 1'b1,
          '{8'h5A, 16'h0000, 4'b1000}},
        '{CMD_UNUSED_FIRST, 8'hA5, 16'h1234, 16'h5678, 4'b1010, 1'b1,
          '{8'hA5, 16'h0000, 4'b1010}},
        '{CMD_UNUSED_LAST,  8'hA5, 16'hFFFF, 16'hFFFF, 4'b0101, 1'b1,
          '{8'hA5, 16'h0000, 4'b0101}},
        '{ecalu_pkg::CMD_ADD,   8'h0F, 16'h0000, 16'h0001, 4'b0000, 1'b0, '0}
    };

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [ecalu_pkg::IN_W-1:0]    s_axis_tdata  = '0;
    logic [ecalu_pkg::CMD_W-1:0]   s_axis_tuser  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [ecalu_pkg::OUT_W-1:0]   m_axis_tdata;

    logic              row_typed     = 1'b0;
    alu_result_t       row_want      = '0;

    alu_result_t       pending_results [$];
    int unsigned       accepted_count = 0;
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count    = 0;
    logic              steady_phase;

    assign steady_phase = (accepted_count >= STEADY_FROM) && (accepted_count < STEADY_TO);

    eight_bit_cpu_alu_with_flags uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    function automatic alu_result_t alu_compute(input logic [ecalu_pkg::CMD_W-1:0] op,
                                                input logic [ecalu_pkg::BYTE_W-1:0] a,
                                                input logic [ecalu_pkg::WORD_W-1:0] hl,
                                                input logic [ecalu_pkg::WORD_W-1:0] opw,
                                                input ecalu_pkg::flags_t fin);
        alu_result_t                  res;
        logic [ecalu_pkg::BYTE_W-1:0] v;
        logic [ecalu_pkg::BYTE_W-1:0] r8;
        logic [ecalu_pkg::BYTE_W-1:0] adj;
        logic [ecalu_pkg::WORD_W-1:0] r16;
        logic [ecalu_pkg::WORD_W:0]   sum;
        logic                         cin;
        logic                         is_add;
        res.acc   = a;
        res.word  = '0;
        res.flags = fin;
        v         = opw[ecalu_pkg::BYTE_W-1:0];
        adj       = '0;
        unique case (op)
            ecalu_pkg::CMD_ADD, ecalu_pkg::CMD_ADC, ecalu_pkg::CMD_SUB,
            ecalu_pkg::CMD_SBC, ecalu_pkg::CMD_CP:
            begin
                is_add = (op == ecalu_pkg::CMD_ADD) || (op == ecalu_pkg::CMD_ADC);
                cin    = ((op == ecalu_pkg::CMD_ADC) || (op == ecalu_pkg::CMD_SBC))
                         ? fin.carry : 1'b0;
                if (is_add)
                    r16 = {8'h00, a} + {8'h00, v} + {15'd0, cin};
                else
                    r16 = {8'h00, a} - {8'h00, v} - {15'd0, cin};
                res.flags.zero  = (r16[7:0] == 8'h00);
                res.flags.sub   = !is_add;
                res.flags.half  = a[4] ^ v[4] ^ r16[4];
                res.flags.carry = |r16[15:8];
                if (op != ecalu_pkg::CMD_CP)
                    res.acc = r16[7:0];
            end
            ecalu_pkg::CMD_AND, ecalu_pkg::CMD_OR, ecalu_pkg::CMD_XOR:
            begin
                if (op == ecalu_pkg::CMD_AND)
                    res.acc = a & v;
                else if (op == ecalu_pkg::CMD_OR)
                    res.acc = a | v;
                else
                    res.acc = a ^ v;
                res.flags.zero  = (res.acc == 8'h00);
                res.flags.sub   = 1'b0;
                res.flags.half  = (op == ecalu_pkg::CMD_AND);
                res.flags.carry = 1'b0;
            end
            ecalu_pkg::CMD_INC8:
            begin
                r8             = v + 8'h01;
                res.word       = {8'h00, r8};
                res.flags.zero = (r8 == 8'h00);
                res.flags.sub  = 1'b0;
                res.flags.half = (v[3:0] == 4'hF);
            end
            ecalu_pkg::CMD_DEC8:
            begin
                r8             = v - 8'h01;
                res.word       = {8'h00, r8};
                res.flags.zero = (r8 == 8'h00);
                res.flags.sub  = 1'b1;
                res.flags.half = (v[3:0] == 4'h0);
            end
            ecalu_pkg::CMD_ADDHL:
            begin
                sum             = {1'b0, hl} + {1'b0, opw};
                res.word        = sum[ecalu_pkg::WORD_W-1:0];
                res.flags.sub   = 1'b0;
                res.flags.half  = hl[12] ^ opw[12] ^ sum[12];
                res.flags.carry = sum[ecalu_pkg::WORD_W];
            end
            ecalu_pkg::CMD_INC16: res.word = opw + 16'h0001;
            ecalu_pkg::CMD_DEC16: res.word = opw - 16'h0001;
            ecalu_pkg::CMD_DAA:
            begin
                if (fin.sub)
                begin
                    if (fin.half)
                        adj = adj + 8'h06;
                    if (fin.carry)
                        adj = adj + 8'h60;
                    res.acc = a - adj;
                end
                else
                begin
                    if (fin.half || (a[3:0] > 4'h9))
                        adj = adj + 8'h06;
                    if (fin.carry || (a > 8'h99))
                    begin
                        adj = adj + 8'h60;
                        res.flags.carry = 1'b1;
                    end
                    res.acc = a + adj;
                end
                res.flags.zero = (res.acc == 8'h00);
                res.flags.half = 1'b0;
            end
            ecalu_pkg::CMD_CPL:
            begin
                res.acc        = ~a;
                res.flags.sub  = 1'b1;
                res.flags.half = 1'b1;
            end
            ecalu_pkg::CMD_CCF:
            begin
                res.flags.carry = ~fin.carry;
                res.flags.sub   = 1'b0;
                res.flags.half  = 1'b0;
            end
            ecalu_pkg::CMD_SCF:
            begin
                res.flags.carry = 1'b1;
                res.flags.sub   = 1'b0;
                res.flags.half  = 1'b0;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [ecalu_pkg::BYTE_W-1:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [ecalu_pkg::WORD_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic check_field(input string field,
                               input logic [ecalu_pkg::WORD_W-1:0] want,
                               input logic [ecalu_pkg::WORD_W-1:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    task automatic send_item(input logic [ecalu_pkg::CMD_W-1:0] op,
                             input logic [ecalu_pkg::BYTE_W-1:0] a,
                             input logic [ecalu_pkg::WORD_W-1:0] hl,
                             input logic [ecalu_pkg::WORD_W-1:0] opw,
                             input ecalu_pkg::flags_t fin, input logic typed,
                             input alu_result_t want);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, fin, opw, hl, a};
        s_axis_tuser  <= op;
        row_typed     <= typed;
        row_want      <= want;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
    endtask

    always @(posedge clk)
    begin : alu_scoreboard
        alu_result_t want;
        alu_result_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.acc   = m_axis_tdata[7:0];
                got.word  = m_axis_tdata[23:8];
                got.flags = m_axis_tdata[27:24];
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result transfer with none expected, actual %h",
                                 $time, m_axis_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("acc_out", {8'h00, want.acc}, {8'h00, got.acc});
                    check_field("word_out", want.word, got.word);
                    check_field("zero_out", {15'd0, want.flags.zero}, {15'd0, got.flags.zero});
                    check_field("sub_out", {15'd0, want.flags.sub}, {15'd0, got.flags.sub});
                    check_field("half_out", {15'd0, want.flags.half}, {15'd0, got.flags.half});
                    check_field("carry_out", {15'd0, want.flags.carry},
                                {15'd0, got.flags.carry});
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                accepted_count <= accepted_count + 1;
                if (row_typed)
                    pending_results.push_back(row_want);
                else
                    pending_results.push_back(alu_compute(s_axis_tuser, s_axis_tdata[7:0],
                                                          s_axis_tdata[23:8],
                                                          s_axis_tdata[39:24],
                                                          s_axis_tdata[43:40]));
            end
        end
    end

    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned burst_left;
        int unsigned r;
        bit          hold_done;
        stall_left = 0;
        burst_left = 0;
        hold_done  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && (accepted_count >= HOLD_AT))
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (!rst_n)
                m_axis_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (burst_left > 0 || steady_phase)
                begin
                    if (burst_left > 0)
                        burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    r          = $urandom_range(0, 99);
                    if (r < 60)
                        stall_left = 0;
                    else if (r < 90)
                        stall_left = $urandom_range(1, 3);
                    else
                        stall_left = $urandom_range(5, 25);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[eight_bit_cpu_alu_with_flags] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned                  i;
        logic [ecalu_pkg::CMD_W-1:0]  op;
        ecalu_pkg::flags_t            fl;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (i = 0; i < N_DIRECTED; i++)
            send_item(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].acc, DIRECTED_ROWS[i].pair,
                      DIRECTED_ROWS[i].opnd, DIRECTED_ROWS[i].flags, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].want);
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                op = 5'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
            else
                op = 5'($urandom_range(ecalu_pkg::CMD_ADD, ecalu_pkg::CMD_SCF));
            fl = 4'($urandom_range(0, 15));
            send_item(op, pick_byte(), pick_word(), pick_word(), fl, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        row_typed     <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[eight_bit_cpu_alu_with_flags] OK");
        else
            $display("[eight_bit_cpu_alu_with_flags] ERROR");
        $finish;
    end

endmodule
